>>> design/rgbyuv_pkg.sv
package rgbyuv_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CHAN_W    = 22;  // clamped value in 8.14 form
  localparam int PAIR_W    = 23;  // sum of two clamped values
  localparam int PROD_W    = 24;  // 9-bit signed pixel times 15-bit coefficient
  localparam int SUM_W     = 26;

  // Q1.14 coefficients, rounded to nearest
  localparam logic signed [14:0] COEF_YR = 15'sd4897;
  localparam logic signed [14:0] COEF_YG = 15'sd9611;
  localparam logic signed [14:0] COEF_YB = 15'sd1876;
  localparam logic signed [14:0] COEF_UR = -15'sd2766;
  localparam logic signed [14:0] COEF_UG = -15'sd5426;
  localparam logic signed [14:0] COEF_UB = 15'sd8192;
  localparam logic signed [14:0] COEF_VR = 15'sd8192;
  localparam logic signed [14:0] COEF_VG = -15'sd6855;
  localparam logic signed [14:0] COEF_VB = -15'sd1337;

  localparam logic signed [SUM_W-1:0] OFFSET_128 = SUM_W'(128 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] CLAMP_TOP  = SUM_W'(255 << FRAC_BITS);

  // configuration register indexes
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [12:0] MAX_FRAME_HEIGHT = 13'd4096;

  typedef struct packed {
    logic col_odd;
    logic row_odd;
    logic frame_end;
  } pos_tag_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic logic [CHAN_W-1:0] clamp814(input logic signed [SUM_W-1:0] v);
    logic [CHAN_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > CLAMP_TOP) begin
      res = CLAMP_TOP[CHAN_W-1:0];
    end else begin
      res = v[CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic prod_t mul_px(input logic [7:0] px, input logic signed [14:0] coef);
    logic signed [8:0] spx;
    prod_t prod;
    spx = $signed({1'b0, px});
    prod = spx * coef;
    return prod;
  endfunction

endpackage

>>> design/rgb_to_yuv420_converter.sv
// Pipeline: product stage loads at the accept edge, then clamp stage, then output register.
// Throughput: one pixel per cycle; a stalled output holds the pipe only once
// every stage is full, empty stages keep taking pixels.
// Line store: one read port and one write port, read data registered.
// Reset clears the position counters, stage valids and left chroma; the line store is not cleared.
module rgb_to_yuv420_converter
  import rgbyuv_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // luma, chroma_u, chroma_v
  output logic        m_axis_tuser,   // chroma_valid
  output logic        m_axis_tlast    // frame_end
);

  localparam int COL_W       = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int STORE_DEPTH = MAX_LINE_WIDTH / 2;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WCMP_W      = 14;
  localparam logic [WCMP_W-1:0] MAX_W = WCMP_W'(MAX_LINE_WIDTH);

  // configuration
  logic [10:0] line_width;
  logic [12:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= 11'd704;
      frame_height <= 13'd480;
    end else if (cfg_we) begin
      if (cfg_index == REG_LINE_WIDTH) begin
        line_width <= cfg_data[10:0];
      end else begin
        frame_height <= cfg_data;
      end
    end
  end

  logic [WCMP_W-1:0] w_eff;
  logic [12:0]       h_eff;

  always_comb begin
    w_eff = WCMP_W'(line_width);
    if (w_eff < WCMP_W'(2)) begin
      w_eff = WCMP_W'(2);
    end else if (w_eff > MAX_W) begin
      w_eff = MAX_W;
    end
    h_eff = frame_height;
    if (h_eff < 13'd2) begin
      h_eff = 13'd2;
    end else if (h_eff > MAX_FRAME_HEIGHT) begin
      h_eff = MAX_FRAME_HEIGHT;
    end
  end

  // stage handshakes: each stage moves when it is empty or its successor moves
  logic p1_valid, p2_valid;
  logic p1_move, p2_move, p3_move;
  logic in_beat;

  assign p3_move       = !m_axis_tvalid || m_axis_tready;
  assign p2_move       = p2_valid && p3_move;
  assign p1_move       = p1_valid && (!p2_valid || p3_move);
  assign s_axis_tready = !p1_valid || !p2_valid || p3_move;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // position counters
  logic [COL_W-1:0] column_count;
  logic [11:0]      row_count;
  logic             last_col, last_row;

  assign last_col = (WCMP_W'(column_count) + WCMP_W'(1)) >= w_eff;
  assign last_row = (13'(row_count) + 13'd1) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_beat) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? 12'd0 : row_count + 12'd1;
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // stage 1: products
  prod_t              p1_yr, p1_yg, p1_yb, p1_ur, p1_ug, p1_ub, p1_vr, p1_vg, p1_vb;
  pos_tag_t           p1_tag;
  logic [STORE_AW-1:0] p1_slot;
  logic [7:0]         px_r, px_g, px_b;

  assign px_r = s_axis_tdata[7:0];
  assign px_g = s_axis_tdata[15:8];
  assign px_b = s_axis_tdata[23:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      p1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      p1_yr <= mul_px(px_r, COEF_YR);
      p1_yg <= mul_px(px_g, COEF_YG);
      p1_yb <= mul_px(px_b, COEF_YB);
      p1_ur <= mul_px(px_r, COEF_UR);
      p1_ug <= mul_px(px_g, COEF_UG);
      p1_ub <= mul_px(px_b, COEF_UB);
      p1_vr <= mul_px(px_r, COEF_VR);
      p1_vg <= mul_px(px_g, COEF_VG);
      p1_vb <= mul_px(px_b, COEF_VB);
      p1_tag.col_odd   <= column_count[0];
      p1_tag.row_odd   <= row_count[0];
      p1_tag.frame_end <= last_col && last_row;
      p1_slot          <= STORE_AW'(column_count >> 1);
    end
  end

  // stage 2: sums, clamp, and line store read
  logic [CHAN_W-1:0]   p2_cy, p2_cu, p2_cv;
  pos_tag_t            p2_tag;
  logic [STORE_AW-1:0] p2_slot;
  logic [CHAN_W-1:0]   s1_cy, s1_cu, s1_cv;

  assign s1_cy = clamp814(SUM_W'(p1_yr) + SUM_W'(p1_yg) + SUM_W'(p1_yb));
  assign s1_cu = clamp814(SUM_W'(p1_ur) + SUM_W'(p1_ug) + SUM_W'(p1_ub) + OFFSET_128);
  assign s1_cv = clamp814(SUM_W'(p1_vr) + SUM_W'(p1_vg) + SUM_W'(p1_vb) + OFFSET_128);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (!p2_valid || p3_move) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      p2_cy   <= s1_cy;
      p2_cu   <= s1_cu;
      p2_cv   <= s1_cv;
      p2_tag  <= p1_tag;
      p2_slot <= p1_slot;
    end
  end

  // line store of even-row pair sums: V sum high, U sum low.
  // The writer of a slot is at least two pixels ahead of its reader, so a
  // read for a chroma block never meets a write to the same slot.
  logic [2*PAIR_W-1:0] pair_mem [STORE_DEPTH];
  logic [2*PAIR_W-1:0] up_pair;
  logic                mem_we;
  logic [PAIR_W-1:0]   wr_su, wr_sv;

  always_ff @(posedge clk) begin
    if (p1_move) begin
      up_pair <= pair_mem[p1_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_mem[p2_slot] <= {wr_sv, wr_su};
    end
  end

  // stage 3: chroma combine into output register
  logic [2*CHAN_W-1:0] left_chroma;  // V high, U low
  logic [23:0]         blk_su, blk_sv;
  logic                chroma_hit;

  assign mem_we     = p2_move && !p2_tag.row_odd && p2_tag.col_odd;
  assign chroma_hit = p2_tag.row_odd && p2_tag.col_odd;
  assign wr_su      = PAIR_W'(left_chroma[CHAN_W-1:0]) + PAIR_W'(p2_cu);
  assign wr_sv      = PAIR_W'(left_chroma[2*CHAN_W-1:CHAN_W]) + PAIR_W'(p2_cv);
  assign blk_su     = 24'(up_pair[PAIR_W-1:0]) + 24'(left_chroma[CHAN_W-1:0]) + 24'(p2_cu);
  assign blk_sv     = 24'(up_pair[2*PAIR_W-1:PAIR_W])
                    + 24'(left_chroma[2*CHAN_W-1:CHAN_W]) + 24'(p2_cv);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_chroma <= '0;
    end else if (p2_move && !p2_tag.col_odd) begin
      left_chroma <= {p2_cv, p2_cu};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (p3_move) begin
      m_axis_tvalid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_move) begin
      m_axis_tdata[7:0] <= p2_cy[CHAN_W-1:FRAC_BITS];
      m_axis_tuser      <= chroma_hit;
      m_axis_tlast      <= p2_tag.frame_end;
      if (chroma_hit) begin
        m_axis_tdata[15:8]  <= blk_su[23:16];
        m_axis_tdata[23:16] <= blk_sv[23:16];
      end else begin
        m_axis_tdata[15:8]  <= 8'd0;
        m_axis_tdata[23:16] <= 8'd0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // an empty output register never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // chroma fields are zero unless the beat carries a 2x2 block
  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:8] == 16'd0))
    else $error("chroma not zero on a luma-only beat");

  // the store read for a chroma block never collides with a pair-sum write
  a_no_store_collision: assert property (@(posedge clk) disable iff (rst)
    (mem_we && p1_move && p1_tag.row_odd && p1_tag.col_odd) |-> (p1_slot != p2_slot))
    else $error("line store read meets write to same slot");

  // a pair-sum write leaves the row/column parity of a chroma beat out
  a_write_not_chroma: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (m_axis_tvalid && !m_axis_tuser))
    else $error("pair-sum write produced a chroma beat");
`endif

endmodule
